@@ hdl/btss_pkg.sv @@
// ----------------------------------------------------------------------------
// btss_pkg
// Shared types and constants for the beacon transmit slot scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package btss_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int MINUTE_W   = 6;
    localparam int SECOND_W   = 6;
    localparam int INTERVAL_W = 6;
    localparam int DURATION_W = 10;
    localparam int WAIT_W     = 12;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BEGIN    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SETTINGS = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd1;

    // Reset values and limits
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 6'd4;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MIN   = 6'd1;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX   = 6'd60;
    localparam logic [DURATION_W-1:0] DURATION_RESET = 10'd110;
    localparam logic [SECOND_W-1:0]   BOUNDARY_SECS  = 6'd2;
    localparam int                    MIN_WAIT       = 5;

    // One remainder bit per step
    localparam int DIV_STEPS  = MINUTE_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE = 2'd0,
        MODE_WAIT = 2'd1,
        MODE_TX   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CALC,
        ST_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic calc;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/btss_ctrl.sv @@
// ----------------------------------------------------------------------------
// btss_ctrl
// Sequencer: accept, remainder steps, wait calculation, state commit.
// ----------------------------------------------------------------------------
`default_nettype none

module btss_ctrl
    import btss_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    ctrl_state_t           state_reg, state_next;
    logic [STEP_CNT_W-1:0] step_cnt_reg, step_cnt_next;
    logic                  last_step;

    assign last_step = (step_cnt_reg == STEP_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    // Next state
    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                step_cnt_next = '0;
                if (s_valid) state_next = ST_DIV;
            end
            ST_DIV: begin
                step_cnt_next = step_cnt_reg + 1'b1;
                if (last_step) state_next = ST_CALC;
            end
            ST_CALC: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_CALC: begin
                cmd.calc = 1'b1;
            end
            ST_COMMIT: begin
                cmd.commit = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/btss_datapath.sv @@
// ----------------------------------------------------------------------------
// btss_datapath
// Configuration, minute remainder unit, slot wait arithmetic, scheduler state
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module btss_datapath
    import btss_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_valid,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data,
    input  wire  [CMD_W-1:0]      s_cmd,
    input  wire  [MINUTE_W-1:0]   s_minute,
    input  wire  [SECOND_W-1:0]   s_second,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic                  m_tx_on,
    output logic [MODE_W-1:0]     m_mode_now,
    output logic                  m_tx_started,
    output logic                  m_tx_ended,
    output logic [WAIT_W-1:0]     m_wait_seconds,
    output logic                  m_armed,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status
);

    localparam int CALC_W = WAIT_W + 2;

    // Configuration
    logic [INTERVAL_W-1:0] interval_reg;
    logic [DURATION_W-1:0] duration_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
            duration_reg <= DURATION_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_INTERVAL) interval_reg <= cfg_data[INTERVAL_W-1:0];
            if (cfg_index == REG_DURATION) duration_reg <= cfg_data[DURATION_W-1:0];
        end
    end

    // Captured item
    logic [CMD_W-1:0]      cmd_reg;
    logic [SECOND_W-1:0]   second_reg;
    logic [INTERVAL_W-1:0] ieff_reg;
    logic [INTERVAL_W-1:0] ieff_in;
    logic [MINUTE_W-1:0]   dividend_reg;
    logic [INTERVAL_W-1:0] rem_reg;
    logic [INTERVAL_W:0]   trial;

    always_comb begin
        if (interval_reg == '0)              ieff_in = INTERVAL_MIN;
        else if (interval_reg > INTERVAL_MAX) ieff_in = INTERVAL_MAX;
        else                                  ieff_in = interval_reg;
    end

    assign trial = {rem_reg, dividend_reg[MINUTE_W-1]};

    // Restoring remainder: minute mod interval, one bit per step
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg      <= s_cmd;
            second_reg   <= s_second;
            ieff_reg     <= ieff_in;
            dividend_reg <= s_minute;
            rem_reg      <= '0;
        end else if (cmd.div_step) begin
            dividend_reg <= {dividend_reg[MINUTE_W-2:0], 1'b0};
            if (trial >= {1'b0, ieff_reg}) rem_reg <= INTERVAL_W'(trial - {1'b0, ieff_reg});
            else                           rem_reg <= trial[INTERVAL_W-1:0];
        end
    end

    // Wait to next slot: (i - r)*60 - s, wrapped up by i*60 if < 0, then again if < 5
    logic [INTERVAL_W:0]      diff;
    logic [CALC_W-1:0]        diff60;
    logic [CALC_W-1:0]        ieff60;
    logic signed [CALC_W-1:0] w0, w1, w2;
    logic [WAIT_W-1:0]        wait_calc_reg;

    assign diff   = {1'b0, ieff_reg} - {1'b0, rem_reg};
    assign diff60 = (CALC_W'(diff) << 6) - (CALC_W'(diff) << 2);
    assign ieff60 = (CALC_W'(ieff_reg) << 6) - (CALC_W'(ieff_reg) << 2);
    assign w0     = $signed(diff60) - $signed(CALC_W'(second_reg));
    assign w1     = (w0 < 0) ? w0 + $signed(ieff60) : w0;
    assign w2     = (w1 < CALC_W'(MIN_WAIT)) ? w1 + $signed(ieff60) : w1;

    always_ff @(posedge aclk) begin
        if (cmd.calc) wait_calc_reg <= w2[WAIT_W-1:0];
    end

    // Scheduler state
    mode_t                 mode_reg, mode_next;
    logic [WAIT_W-1:0]     wait_reg, wait_next, wait_dec;
    logic                  armed_reg, armed_next;
    logic [DURATION_W-1:0] txc_reg, txc_next;
    logic                  started, ended;
    logic                  boundary;

    assign boundary = (rem_reg == '0) && (second_reg < BOUNDARY_SECS);
    assign wait_dec = (wait_reg != '0) ? wait_reg - 1'b1 : wait_reg;

    always_comb begin
        mode_next  = mode_reg;
        wait_next  = wait_reg;
        armed_next = armed_reg;
        txc_next   = txc_reg;
        started    = 1'b0;
        ended      = 1'b0;
        case (cmd_reg)
            CMD_TICK: begin
                if (mode_reg == MODE_TX) begin
                    if (txc_reg <= DURATION_W'(1)) begin
                        txc_next   = '0;
                        ended      = 1'b1;
                        mode_next  = MODE_WAIT;
                        wait_next  = wait_calc_reg;
                        armed_next = 1'b1;
                    end else begin
                        txc_next = txc_reg - 1'b1;
                    end
                end else if (armed_reg) begin
                    wait_next = wait_dec;
                    if (wait_dec == '0) begin
                        // missed slot leaves the countdown disarmed
                        armed_next = 1'b0;
                        if (boundary) begin
                            mode_next = MODE_TX;
                            txc_next  = duration_reg;
                            started   = 1'b1;
                        end
                    end
                end
            end
            CMD_BEGIN: begin
                if (mode_reg == MODE_TX) begin
                    ended    = 1'b1;
                    txc_next = '0;
                end
                mode_next  = MODE_WAIT;
                wait_next  = wait_calc_reg;
                armed_next = 1'b1;
            end
            CMD_SETTINGS: begin
                if (mode_reg == MODE_TX) begin
                    txc_next = '0;
                    ended    = 1'b1;
                end
                if (mode_reg == MODE_TX || boundary) begin
                    mode_next  = MODE_WAIT;
                    wait_next  = wait_calc_reg;
                    armed_next = 1'b1;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            wait_reg  <= '0;
            armed_reg <= 1'b0;
            txc_reg   <= '0;
        end else if (cmd.commit) begin
            mode_reg  <= mode_next;
            wait_reg  <= wait_next;
            armed_reg <= armed_next;
            txc_reg   <= txc_next;
        end
    end

    // Result register
    logic m_valid_reg;

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tx_on        <= (mode_next == MODE_TX);
            m_mode_now     <= mode_next;
            m_tx_started   <= started;
            m_tx_ended     <= ended;
            m_wait_seconds <= armed_next ? wait_next : '0;
            m_armed        <= armed_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/beacon_transmit_slot_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// beacon_transmit_slot_scheduler_unit
// Keeps a beacon transmitter on wall-clock slots of a configurable period.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one command (tick, begin, settings changed) with the current
//   minute and second per transaction. m_* channel: exactly one result per
//   input transaction, in order: key state, mode, start/end pulses, countdown.
//   cfg_* channel: writes interval (index 0) or duration (index 1); always
//   ready, to be used only while no transaction is in flight.
// Sequence:
//   A result is registered at the commit that follows acceptance of the input
//   transaction; the next input is taken only after that commit, so items do
//   not overlap. The path runs through the minute-mod-interval remainder unit
//   (6 steps), the slot wait arithmetic and the commit step.
// Reset (aresetn low, synchronous): mode idle, countdown disarmed, interval 4,
//   duration 110, no result pending.
// Stall: the result sits in the output register while m_ready is low; a new
//   input may be accepted and processed meanwhile, but its commit waits until
//   the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module beacon_transmit_slot_scheduler_unit
    import btss_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [CMD_W-1:0]      s_cmd,
    input  wire  [MINUTE_W-1:0]   s_minute,
    input  wire  [SECOND_W-1:0]   s_second,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic                  m_tx_on,
    output logic [MODE_W-1:0]     m_mode_now,
    output logic                  m_tx_started,
    output logic                  m_tx_ended,
    output logic [WAIT_W-1:0]     m_wait_seconds,
    output logic                  m_armed
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    btss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    btss_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_cmd          (s_cmd),
        .s_minute       (s_minute),
        .s_second       (s_second),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tx_on        (m_tx_on),
        .m_mode_now     (m_mode_now),
        .m_tx_started   (m_tx_started),
        .m_tx_ended     (m_tx_ended),
        .m_wait_seconds (m_wait_seconds),
        .m_armed        (m_armed),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

`default_nettype wire

@@ hdl/btss_checker.sv @@
// ----------------------------------------------------------------------------
// btss_checker
// Port-level checks on the result channel of the slot scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

module btss_checker
    import btss_pkg::*;
(
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  m_valid,
    input wire                  m_ready,
    input wire                  m_tx_on,
    input wire [MODE_W-1:0]     m_mode_now,
    input wire                  m_tx_started,
    input wire                  m_tx_ended,
    input wire [WAIT_W-1:0]     m_wait_seconds,
    input wire                  m_armed
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mode_now)
            && $stable(m_wait_seconds) && $stable(m_tx_started))
        else $error("result changed while stalled");

    // A start lands in transmit mode and never coincides with an end
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_started |-> m_tx_on && !m_tx_ended
            && (m_mode_now == MODE_TX) && !m_armed)
        else $error("start pulse inconsistent");

    // Countdown shows zero unless armed
    a_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_armed |-> m_wait_seconds == '0)
        else $error("countdown reported while disarmed");

    // An end leaves the transmitter unkeyed and waiting on a fresh countdown
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_ended |-> !m_tx_on && (m_mode_now == MODE_WAIT) && m_armed
            && (m_wait_seconds != '0))
        else $error("end pulse inconsistent");

endmodule

bind beacon_transmit_slot_scheduler_unit btss_checker u_btss_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_tx_on        (m_tx_on),
    .m_mode_now     (m_mode_now),
    .m_tx_started   (m_tx_started),
    .m_tx_ended     (m_tx_ended),
    .m_wait_seconds (m_wait_seconds),
    .m_armed        (m_armed)
);

`default_nettype wire

@@ tb/btss_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btss_result_checker
// Watches the register, command and result channels of the slot scheduler,
// keeps its own model of the schedule and compares every result transaction
// field by field with the expectation queued for the oldest open command.
// ----------------------------------------------------------------------------

module btss_result_checker
    import btss_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_valid,
    input  wire                   cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data,
    input  wire                   s_valid,
    input  wire                   s_ready,
    input  wire  [CMD_W-1:0]      s_cmd,
    input  wire  [MINUTE_W-1:0]   s_minute,
    input  wire  [SECOND_W-1:0]   s_second,
    input  wire                   m_valid,
    input  wire                   m_ready,
    input  wire                   m_tx_on,
    input  wire  [MODE_W-1:0]     m_mode_now,
    input  wire                   m_tx_started,
    input  wire                   m_tx_ended,
    input  wire  [WAIT_W-1:0]     m_wait_seconds,
    input  wire                   m_armed,
    output int                    fail_count,
    output int                    pending,
    output int                    tx_starts,
    output int                    tx_ends
);

    localparam int SECS_PER_MIN = 60;

    typedef struct {
        logic              tx_on;
        logic [MODE_W-1:0] mode_now;
        logic              started;
        logic              ended;
        logic [WAIT_W-1:0] wait_s;
        logic              armed;
    } slot_report_t;

    slot_report_t expected_reports[$];

    // Scheduler model state
    mode_t                 sched_mode;
    logic [WAIT_W-1:0]     slot_wait;
    logic                  slot_armed;
    logic [DURATION_W-1:0] key_left;
    logic                  cancelled;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [DURATION_W-1:0] duration_reg;

    // Out-of-range interval values are clamped into 1..60
    function automatic int slot_period();
        if (interval_reg < INTERVAL_MIN) return INTERVAL_MIN;
        if (interval_reg > INTERVAL_MAX) return INTERVAL_MAX;
        return interval_reg;
    endfunction

    function automatic logic at_slot_start(logic [MINUTE_W-1:0] mi, logic [SECOND_W-1:0] se);
        return ((int'(mi) % slot_period()) == 0) && (se < BOUNDARY_SECS);
    endfunction

    function automatic logic [WAIT_W-1:0] seconds_to_slot(logic [MINUTE_W-1:0] mi,
                                                          logic [SECOND_W-1:0] se);
        int p;
        int w;
        p = slot_period();
        w = (p - (int'(mi) % p)) * SECS_PER_MIN - int'(se);
        if (w < 0) w += p * SECS_PER_MIN;
        if (w < MIN_WAIT) w += p * SECS_PER_MIN;
        return WAIT_W'(w);
    endfunction

    task automatic arm_slot(input logic [MINUTE_W-1:0] mi, input logic [SECOND_W-1:0] se);
        slot_wait  = seconds_to_slot(mi, se);
        slot_armed = 1'b1;
    endtask

    task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [MINUTE_W-1:0] mi,
                                 input logic [SECOND_W-1:0] se, output slot_report_t rep);
        logic started;
        logic ended;
        started = 1'b0;
        ended   = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (sched_mode == MODE_TX) begin
                    if (key_left <= 1) begin
                        key_left   = '0;
                        ended      = 1'b1;
                        sched_mode = MODE_WAIT;
                        arm_slot(mi, se);
                    end else begin
                        key_left--;
                    end
                end else if (slot_armed) begin
                    if (slot_wait != 0) slot_wait--;
                    if (slot_wait == 0) begin
                        // countdown expired: key up only on a slot boundary
                        slot_armed = 1'b0;
                        if (at_slot_start(mi, se)) begin
                            sched_mode = MODE_TX;
                            cancelled  = 1'b0;
                            key_left   = duration_reg;
                            started    = 1'b1;
                        end
                    end
                end
            end
            CMD_BEGIN: begin
                if (sched_mode == MODE_TX) begin
                    ended    = 1'b1;
                    key_left = '0;
                end
                sched_mode = MODE_WAIT;
                cancelled  = 1'b0;
                arm_slot(mi, se);
            end
            CMD_SETTINGS: begin
                if (sched_mode == MODE_TX) begin
                    cancelled  = 1'b1;
                    key_left   = '0;
                    ended      = 1'b1;
                    sched_mode = MODE_WAIT;
                    arm_slot(mi, se);
                end
                if (at_slot_start(mi, se)) begin
                    sched_mode = MODE_WAIT;
                    cancelled  = 1'b0;
                    arm_slot(mi, se);
                end
            end
            default: ;
        endcase
        rep.tx_on    = (sched_mode == MODE_TX);
        rep.mode_now = sched_mode;
        rep.started  = started;
        rep.ended    = ended;
        rep.wait_s   = slot_armed ? slot_wait : '0;
        rep.armed    = slot_armed;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        slot_report_t want;
        if (!aresetn) begin
            sched_mode   = MODE_IDLE;
            slot_wait    = '0;
            slot_armed   = 1'b0;
            key_left     = '0;
            cancelled    = 1'b0;
            interval_reg = INTERVAL_RESET;
            duration_reg = DURATION_RESET;
            expected_reports.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_INTERVAL: interval_reg = cfg_data[INTERVAL_W-1:0];
                    REG_DURATION: duration_reg = cfg_data[DURATION_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result transaction with no command outstanding");
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("tx_on", want.tx_on, m_tx_on);
                    check_field("mode_now", want.mode_now, m_mode_now);
                    check_field("tx_started", want.started, m_tx_started);
                    check_field("tx_ended", want.ended, m_tx_ended);
                    check_field("wait_seconds", want.wait_s, m_wait_seconds);
                    check_field("armed", want.armed, m_armed);
                    if (m_tx_started) tx_starts++;
                    if (m_tx_ended) tx_ends++;
                end
            end
            if (s_valid && s_ready) begin
                apply_command(s_cmd, s_minute, s_second, want);
                expected_reports.push_back(want);
            end
        end
        pending = expected_reports.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the slot scheduler with directed corner cases and then with a
// simulated wall clock of ticks, begin and settings commands plus noise,
// under several register settings and back-pressure patterns.
// ----------------------------------------------------------------------------

module tb_top;
    import btss_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;
    localparam int                   SETTLE_CYCLES = 16;
    localparam int                   HOLD_CYCLES   = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_INTERVAL;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd     = CMD_TICK;
    logic [MINUTE_W-1:0]   s_minute  = '0;
    logic [SECOND_W-1:0]   s_second  = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_tx_on;
    logic [MODE_W-1:0]     m_mode_now;
    logic                  m_tx_started;
    logic                  m_tx_ended;
    logic [WAIT_W-1:0]     m_wait_seconds;
    logic                  m_armed;

    int fail_count;
    int pending;
    int tx_starts;
    int tx_ends;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;
    int hold_left   = 0;
    int cmds_sent   = 0;
    int reg_writes  = 0;
    int cfg_period  = INTERVAL_RESET;
    int wall_min    = 0;
    int wall_sec    = 0;

    beacon_transmit_slot_scheduler_unit DUT (.*);
    btss_result_checker u_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: random back-pressure, or a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #4ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int stim_period();
        if (cfg_period < INTERVAL_MIN) return INTERVAL_MIN;
        if (cfg_period > INTERVAL_MAX) return INTERVAL_MAX;
        return cfg_period;
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [MINUTE_W-1:0] mi,
                            input logic [SECOND_W-1:0] se);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_cmd    = cmd;
        s_minute = mi;
        s_second = se;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        cmds_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        if (idx == REG_INTERVAL) cfg_period = data[INTERVAL_W-1:0];
        reg_writes++;
    endtask

    // Wait until every result is back, then let the pipeline drain
    task automatic settle();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic advance_clock();
        wall_sec++;
        if (wall_sec == 60) begin
            wall_sec = 0;
            wall_min = (wall_min + 1) % 60;
        end
    endtask

    // Mostly a running wall clock; begin/settings sometimes jump next to a slot
    task automatic random_items(input int n);
        int pick;
        int p;
        int k;
        repeat (n) begin
            pick = $urandom_range(99);
            p    = stim_period();
            if (pick < 78) begin
                send_cmd(CMD_TICK, 6'(wall_min), 6'(wall_sec));
                advance_clock();
            end else if (pick < 85) begin
                if ($urandom_range(1)) begin
                    k        = $urandom_range(60 / p - 1);
                    wall_min = p * k + p - 1;
                    wall_sec = $urandom_range(30, 59);
                end
                send_cmd(CMD_BEGIN, 6'(wall_min), 6'(wall_sec));
                if ($urandom_range(9) != 0) advance_clock();
            end else if (pick < 90) begin
                if ($urandom_range(1)) begin
                    k        = $urandom_range(60 / p - 1);
                    wall_min = p * k;
                    wall_sec = $urandom_range(1);
                end
                send_cmd(CMD_SETTINGS, 6'(wall_min), 6'(wall_sec));
                advance_clock();
            end else if (pick < 93) begin
                send_cmd(CMD_UNUSED, 6'($urandom), 6'($urandom));
            end else if (pick < 96) begin
                send_cmd(CMD_TICK, 6'($urandom), 6'($urandom));
            end else begin
                // clock jump, often lands a countdown expiry off the slot
                wall_min = $urandom_range(59);
                wall_sec = $urandom_range(59);
                send_cmd(CMD_TICK, 6'(wall_min), 6'(wall_sec));
                advance_clock();
            end
        end
    endtask

    task automatic run_phase(input int n, input int tx_pct, input int rx_pct,
                             input logic [CFG_DATA_W-1:0] interval_data,
                             input logic [CFG_DATA_W-1:0] duration_data);
        settle();
        write_reg(REG_INTERVAL, interval_data);
        write_reg(REG_DURATION, duration_data);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        wall_min    = $urandom_range(59);
        wall_sec    = $urandom_range(59);
        random_items(n);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn     = 1'b1;
        tx_idle_pct = 14;
        rx_idle_pct = 78;

        // Reset settings: idle tick, ignored command, settings off and on a boundary,
        // short-wait wrap, a slot hit and a cancel while keyed
        send_cmd(CMD_TICK, 6'd0, 6'd0);
        send_cmd(CMD_UNUSED, 6'd63, 6'd63);
        send_cmd(CMD_SETTINGS, 6'd5, 6'd30);
        send_cmd(CMD_SETTINGS, 6'd8, 6'd1);
        send_cmd(CMD_BEGIN, 6'd3, 6'd58);
        send_cmd(CMD_BEGIN, 6'd3, 6'd55);
        for (int se = 56; se < 60; se++) send_cmd(CMD_TICK, 6'd3, 6'(se));
        send_cmd(CMD_TICK, 6'd4, 6'd0);
        send_cmd(CMD_SETTINGS, 6'd4, 6'd1);

        // Interval above range, zero duration: longest wait, then a one-tick keying
        settle();
        write_reg(REG_INTERVAL, 10'd63);
        write_reg(REG_DURATION, 10'd0);
        send_cmd(CMD_BEGIN, 6'd59, 6'd56);
        send_cmd(CMD_BEGIN, 6'd59, 6'd55);
        for (int se = 56; se < 60; se++) send_cmd(CMD_TICK, 6'd59, 6'(se));
        send_cmd(CMD_TICK, 6'd0, 6'd0);
        send_cmd(CMD_TICK, 6'd0, 6'd1);

        // Zero interval, longest duration, unused register; countdown misses its slot
        settle();
        write_reg(REG_UNUSED, 10'h3FF);
        write_reg(REG_INTERVAL, 10'd0);
        write_reg(REG_DURATION, 10'd1023);
        send_cmd(CMD_BEGIN, 6'd2, 6'd55);
        for (int se = 56; se < 60; se++) send_cmd(CMD_TICK, 6'd2, 6'(se));
        send_cmd(CMD_TICK, 6'd2, 6'd30);

        run_phase(205, 14, 78, 10'd1, 10'd3);
        run_phase(205, 14, 78, {4'hF, 6'd2}, 10'd1);
        run_phase(205, 78, 14, 10'd60, 10'd0);
        run_phase(205, 78, 14, 10'($urandom_range(3, 6)), 10'($urandom_range(2, 12)));
        run_phase(100, 0, 0, 10'd0, 10'($urandom_range(1, 8)));

        // Result side holds off while commands keep coming, then a full drain
        hold_req = 1'b1;
        random_items(30);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        random_items(75);

        run_phase(205, 0, 0, 10'($urandom_range(61, 63)), 10'd1023);

        settle();
        $display("Run covered %0d commands and %0d register writes over nine settings,",
                 cmds_sent, reg_writes);
        $display("with %0d transmissions keyed and %0d ended in the checked results.",
                 tx_starts, tx_ends);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/btss_pkg.sv
hdl/btss_ctrl.sv
hdl/btss_datapath.sv
hdl/beacon_transmit_slot_scheduler_unit.sv
hdl/btss_checker.sv
tb/btss_result_checker.sv
tb/tb_top.sv
